// ===== hw/rtl/lhp_pkg.sv =====
// ----------------------------------------------------------------------------
// Latency histogram package
// Shared codes, command and status bundles for the histogram block.
// ----------------------------------------------------------------------------
package lhp_pkg;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    localparam logic [9:0]  TENTHS_MAX   = 10'd1000;
    localparam logic [31:0] TENTHS_SCALE = 32'd1000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     cap_rec;
        logic     cap_rep;
        logic     stats_clr;
        logic     div_start;
        logic     idx_zero;
        logic     idx_inc;
        logic     idx_load;
        logic     mem_clr_we;
        logic     mem_bkt_we;
        logic     mean_load;
        logic     walk_init;
        logic     walk_step;
        logic     pct_hit;
        logic     pct_max;
        logic     out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;
        logic count_zero;
        logic div_busy;
        logic div_done;
        logic hit;
        logic last_bin;
    } stat_t;

endpackage

// ===== hw/rtl/lhp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module lhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lhp_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring 64 by 32 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lhp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[63]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 32'(shifted - {1'b0, dsr_reg}) : shifted[31:0];
            quo_next = {quo_reg[62:0], fits};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/lhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Histogram controller
// Sequences clearing, bucket updates, the mean division and the percentile walk.
// ----------------------------------------------------------------------------
module lhp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     kind,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  lhp_pkg::stat_t stat,
    output lhp_pkg::cmd_t  cmd
);
    import lhp_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_BRD   = 8'b00000100,
        S_BWR   = 8'b00001000,
        S_MDIV  = 8'b00010000,
        S_WRD   = 8'b00100000,
        S_WCMP  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   load_ok;

    assign accept  = in_valid && (state_reg == S_IDLE);
    assign load_ok = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.mem_clr_we = 1'b1;
                cmd.idx_inc    = 1'b1;
                if (stat.last_bin)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(kind))
                        KIND_RECORD:
                        begin
                            cmd.cap_rec = 1'b1;
                            if (stat.in_range)
                            begin
                                cmd.idx_load = 1'b1;
                                state_next   = S_BRD;
                            end
                        end
                        KIND_REPORT:
                        begin
                            cmd.cap_rep = 1'b1;
                            if (stat.count_zero)
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = S_MDIV;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            cmd.stats_clr = 1'b1;
                            cmd.idx_zero  = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BRD:
            begin
                state_next = S_BWR;
            end
            S_BWR:
            begin
                cmd.mem_bkt_we = 1'b1;
                state_next     = S_IDLE;
            end
            S_MDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_load = 1'b1;
                    cmd.walk_init = 1'b1;
                    cmd.idx_zero  = 1'b1;
                    state_next    = S_WRD;
                end
            end
            S_WRD:
            begin
                state_next = S_WCMP;
            end
            S_WCMP:
            begin
                if (stat.hit)
                begin
                    cmd.pct_hit = 1'b1;
                    state_next  = S_OUT;
                end
                else if (stat.last_bin)
                begin
                    cmd.pct_max = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = S_WRD;
                end
            end
            S_OUT:
            begin
                if (load_ok)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/lhp_dp.sv =====
// ----------------------------------------------------------------------------
// Histogram datapath
// Statistics registers, bucket memory, mean divider and percentile walk.
// ----------------------------------------------------------------------------
module lhp_dp #(
    parameter int NUM_BINS  = 1024,
    parameter int BIN_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [47:0]    latency,
    input  logic [9:0]     percentile_tenths,
    input  lhp_pkg::cmd_t  cmd,
    output lhp_pkg::stat_t stat,
    output logic [31:0]    sample_total,
    output logic [47:0]    min_latency,
    output logic [47:0]    max_latency,
    output logic [63:0]    mean_latency,
    output logic [47:0]    percentile_value,
    output logic [31:0]    overflow_total
);
    import lhp_pkg::*;

    // Bucket widths are powers of two, so the bucket index is a shift.
    localparam int          IDXW        = $clog2(NUM_BINS);
    localparam int          BIN_SHIFT   = $clog2(BIN_WIDTH);
    localparam logic [63:0] TRACK_LIMIT = 64'(NUM_BINS) * 64'(BIN_WIDTH);
    localparam logic [47:0] MID_FIRST   = 48'(BIN_WIDTH / 2);
    localparam logic [47:0] MID_STEP    = 48'(BIN_WIDTH);
    localparam logic [63:0] SCALE64     = 64'(TENTHS_SCALE);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_BINS - 1);

    logic [31:0] count_reg;
    logic [63:0] sum_reg;
    logic [47:0] min_reg;
    logic [47:0] max_reg;
    logic [31:0] overflow_reg;
    logic        zero_reg;
    logic [IDXW-1:0] idx_reg;
    logic [63:0] mean_reg;
    logic [63:0] prod_reg;
    logic [63:0] run_reg;
    logic [47:0] mid_reg;
    logic [47:0] pct_reg;

    logic [31:0] ost_reg, oov_reg;
    logic [47:0] omin_reg, omax_reg, opct_reg;
    logic [63:0] omean_reg;

    logic        div_busy, div_done;
    logic [63:0] div_q;

    logic            mem_we;
    logic [31:0]     mem_wdata;
    logic [31:0]     mem_rdata;
    logic [63:0]     run_sum;
    logic [9:0]      tenths_sat;

    lhp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mem_we    = cmd.mem_clr_we || cmd.mem_bkt_we;
    assign mem_wdata = cmd.mem_clr_we ? 32'd0 :
                       ((mem_rdata == 32'hFFFF_FFFF) ? mem_rdata : mem_rdata + 32'd1);

    lhp_ram #(
        .WIDTH (32),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    assign tenths_sat = (percentile_tenths > TENTHS_MAX) ? TENTHS_MAX : percentile_tenths;

    // The walk keeps 1000 * (running + 1); running reaches floor(t * n / 1000)
    // exactly when that scaled value exceeds t * n.
    assign run_sum = run_reg + 64'(mem_rdata) * SCALE64;

    assign stat.in_range   = {16'd0, latency} < TRACK_LIMIT;
    assign stat.count_zero = (count_reg == 32'd0);
    assign stat.div_busy   = div_busy;
    assign stat.div_done   = div_done;
    assign stat.hit        = run_sum > prod_reg;
    assign stat.last_bin   = (idx_reg == LAST_IDX);

    // Statistics and index are control state; reset or clear puts them back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            min_reg      <= '1;
            max_reg      <= '0;
            overflow_reg <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cmd.stats_clr)
            begin
                count_reg    <= '0;
                sum_reg      <= '0;
                min_reg      <= '1;
                max_reg      <= '0;
                overflow_reg <= '0;
            end
            else if (cmd.cap_rec)
            begin
                if (count_reg != 32'hFFFF_FFFF)
                begin
                    count_reg <= count_reg + 32'd1;
                end
                sum_reg <= sum_reg + {16'd0, latency};
                if (latency < min_reg)
                begin
                    min_reg <= latency;
                end
                if (latency > max_reg)
                begin
                    max_reg <= latency;
                end
                if (!stat.in_range && (overflow_reg != 32'hFFFF_FFFF))
                begin
                    overflow_reg <= overflow_reg + 32'd1;
                end
            end

            if (cmd.idx_zero)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_load)
            begin
                idx_reg <= IDXW'(latency >> BIN_SHIFT);
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDXW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_rep)
        begin
            prod_reg <= 64'(tenths_sat) * 64'(count_reg);
            zero_reg <= (count_reg == 32'd0);
        end
        if (cmd.mean_load)
        begin
            mean_reg <= div_q;
        end
        if (cmd.walk_init)
        begin
            run_reg <= SCALE64;
            mid_reg <= MID_FIRST;
        end
        else if (cmd.walk_step)
        begin
            run_reg <= run_sum;
            mid_reg <= mid_reg + MID_STEP;
        end
        if (cmd.pct_hit)
        begin
            pct_reg <= mid_reg;
        end
        else if (cmd.pct_max)
        begin
            pct_reg <= max_reg;
        end
        if (cmd.out_load)
        begin
            if (zero_reg)
            begin
                ost_reg   <= '0;
                omin_reg  <= '0;
                omax_reg  <= '0;
                omean_reg <= '0;
                opct_reg  <= '0;
                oov_reg   <= '0;
            end
            else
            begin
                ost_reg   <= count_reg;
                omin_reg  <= min_reg;
                omax_reg  <= max_reg;
                omean_reg <= mean_reg;
                opct_reg  <= pct_reg;
                oov_reg   <= overflow_reg;
            end
        end
    end

    assign sample_total     = ost_reg;
    assign min_latency      = omin_reg;
    assign max_latency      = omax_reg;
    assign mean_latency     = omean_reg;
    assign percentile_value = opct_reg;
    assign overflow_total   = oov_reg;

endmodule

// ===== hw/rtl/latency_histogram_percentile.sv =====
// ----------------------------------------------------------------------------
// Latency histogram with percentile report
// Records latency samples into a bucket histogram and reports statistics.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, kind, latency,
// percentile_tenths) carries one transaction per item. Kind record stores a
// sample, kind report returns one output transaction, kind clear wipes all
// statistics; the unused kind is dropped. BIN_WIDTH is a power of two.
// Sequence: a record outside the tracked range never leaves the idle state. A
// record in range goes on: the accept cycle loads the bucket index (a shift
// of the sample), then a read-modify-write of the bucket memory.
// A report runs the bit-serial divider for the mean and then walks the
// buckets, each through a read state and a compare state on the memory's
// registered read port, at most NUM_BINS buckets. With no samples it skips
// both and goes straight to the output.
// A clear, and reset, sweep the bucket memory one entry a cycle; in_stall
// is high during the sweep.
// Output: the result sits in an output register; a stalled receiver only
// delays the next report, and records are still accepted meanwhile.
// ----------------------------------------------------------------------------
module latency_histogram_percentile #(
    parameter int NUM_BINS  = 1024,
    parameter int BIN_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [47:0] latency,
    input  logic [9:0]  percentile_tenths,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample_total,
    output logic [47:0] min_latency,
    output logic [47:0] max_latency,
    output logic [63:0] mean_latency,
    output logic [47:0] percentile_value,
    output logic [31:0] overflow_total
);
    import lhp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The controller owns sequencing and the output valid flag.
    lhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds every statistic, the histogram and the divider.
    lhp_dp #(
        .NUM_BINS  (NUM_BINS),
        .BIN_WIDTH (BIN_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .latency           (latency),
        .percentile_tenths (percentile_tenths),
        .cmd               (cmd),
        .stat              (stat),
        .sample_total      (sample_total),
        .min_latency       (min_latency),
        .max_latency       (max_latency),
        .mean_latency      (mean_latency),
        .percentile_value  (percentile_value),
        .overflow_total    (overflow_total)
    );

    // A waiting result is never overwritten by a new report.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("report result overwrote a pending output");

    // The divider is only started when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    // Clearing and bucket updates never write the memory together.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_clr_we |-> !cmd.mem_bkt_we)
        else $error("conflicting bucket memory writes");

    // An accepted clear always leaves the idle state for the memory sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_CLEAR) |=> in_stall)
        else $error("clear did not start the memory sweep");

endmodule

// ===== bench/latency_histogram_percentile_test.sv =====
// ----------------------------------------------------------------------------
// Latency histogram testbench
// Drives record, report, clear and unused-kind transactions into the histogram block,
// predicts every report from a local copy of the statistics and bucket
// counters, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module latency_histogram_percentile_test;

    import lhp_pkg::*;

    localparam int          BINS      = 1024;
    localparam int          BUCKET_W  = 16;
    localparam logic [63:0] TRACKED   = 64'(BINS) * 64'(BUCKET_W);
    localparam logic [47:0] ALL48     = {48{1'b1}};
    localparam logic [31:0] ALL32     = {32{1'b1}};

    typedef struct packed {
        logic [31:0] total;
        logic [47:0] lo;
        logic [47:0] hi;
        logic [63:0] mean;
        logic [47:0] pct;
        logic [31:0] ovf;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [47:0] latency;
    logic [9:0]  percentile_tenths;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] sample_total;
    logic [47:0] min_latency;
    logic [47:0] max_latency;
    logic [63:0] mean_latency;
    logic [47:0] percentile_value;
    logic [31:0] overflow_total;

    // Local copy of the block's statistics.
    logic [31:0] n_samples;
    logic [63:0] lat_sum;
    logic [47:0] lat_min;
    logic [47:0] lat_max;
    logic [31:0] n_over;
    logic [31:0] hist [BINS];

    report_t pending_reports [$];
    int      failures;
    int      send_idle_pct;
    int      recv_stall_pct;

    latency_histogram_percentile uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .kind              (kind),
        .latency           (latency),
        .percentile_tenths (percentile_tenths),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .sample_total      (sample_total),
        .min_latency       (min_latency),
        .max_latency       (max_latency),
        .mean_latency      (mean_latency),
        .percentile_value  (percentile_value),
        .overflow_total    (overflow_total)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == ALL32) ? v : v + 32'd1;
    endfunction

    function automatic void wipe_stats();
        n_samples = '0;
        lat_sum   = '0;
        lat_min   = ALL48;
        lat_max   = '0;
        n_over    = '0;
        foreach (hist[i])
            hist[i] = '0;
    endfunction

    // Walks the buckets from zero until the running sum reaches the target;
    // falls back to the maximum when the target lies in the overflow region.
    function automatic logic [47:0] pick_percentile(input logic [9:0] tenths);
        logic [63:0] t;
        logic [63:0] goal;
        logic [63:0] running;
        t = (tenths > TENTHS_MAX) ? 64'(TENTHS_MAX) : 64'(tenths);
        goal = (t * 64'(n_samples)) / 64'd1000;
        running = '0;
        for (int i = 0; i < BINS; i++)
        begin
            running += 64'(hist[i]);
            if (running >= goal)
                return 48'(64'(i) * BUCKET_W + BUCKET_W / 2);
        end
        return lat_max;
    endfunction

    // Applies one accepted transaction to the local statistics.
    function automatic void apply_transaction(input logic [1:0] k, input logic [47:0] lat,
                                              input logic [9:0] tenths);
        report_t r;
        case (k)
            KIND_RECORD:
            begin
                n_samples = bump(n_samples);
                lat_sum   = lat_sum + 64'(lat);
                if (lat < lat_min)
                    lat_min = lat;
                if (lat > lat_max)
                    lat_max = lat;
                if (64'(lat) < TRACKED)
                    hist[lat / BUCKET_W] = bump(hist[lat / BUCKET_W]);
                else
                    n_over = bump(n_over);
            end
            KIND_REPORT:
            begin
                r = '0;
                if (n_samples != 0)
                begin
                    r.total = n_samples;
                    r.lo    = lat_min;
                    r.hi    = lat_max;
                    r.mean  = lat_sum / 64'(n_samples);
                    r.pct   = pick_percentile(tenths);
                    r.ovf   = n_over;
                end
                pending_reports.push_back(r);
            end
            KIND_CLEAR:
                wipe_stats();
            default:
            begin
            end
        endcase
    endfunction

    // Sends one transaction, holding it until the block takes it. Valid stays
    // high after acceptance so the next item can follow without a gap.
    task automatic send_item(input logic [1:0] k, input logic [47:0] lat,
                             input logic [9:0] tenths);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        kind              <= k;
        latency           <= lat;
        percentile_tenths <= tenths;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_transaction(k, lat, tenths);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall, compare each accepted report with the oldest one.
    always @(posedge clk)
    begin
        report_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("unexpected report transaction");
                    failures++;
                end
                else
                begin
                    e = pending_reports.pop_front();
                    if (sample_total !== e.total)
                    begin
                        $error("sample_total exp %0d got %0d", e.total, sample_total);
                        failures++;
                    end
                    if (min_latency !== e.lo)
                    begin
                        $error("min_latency exp %0d got %0d", e.lo, min_latency);
                        failures++;
                    end
                    if (max_latency !== e.hi)
                    begin
                        $error("max_latency exp %0d got %0d", e.hi, max_latency);
                        failures++;
                    end
                    if (mean_latency !== e.mean)
                    begin
                        $error("mean_latency exp %0d got %0d", e.mean, mean_latency);
                        failures++;
                    end
                    if (percentile_value !== e.pct)
                    begin
                        $error("percentile_value exp %0d got %0d", e.pct, percentile_value);
                        failures++;
                    end
                    if (overflow_total !== e.ovf)
                    begin
                        $error("overflow_total exp %0d got %0d", e.ovf, overflow_total);
                        failures++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Mostly tracked-range samples, some near the bucket edges, some near the tracked limit, a few huge.
    function automatic logic [47:0] rand_latency();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 48'($urandom_range(TRACKED - 1));
        else if (sel < 75)
            return 48'($urandom_range(40)) * BUCKET_W + 48'($urandom_range(1)) * (BUCKET_W - 1);
        else if (sel < 90)
            return TRACKED[47:0] + 48'($urandom_range(255)) - 48'd8;
        return 48'({$urandom, $urandom});
    endfunction

    task automatic test_empty_and_edges();
        send_item(KIND_REPORT, '0, 10'd500);
        send_item(KIND_RECORD, 48'd0, '0);
        send_item(KIND_REPORT, '0, 10'd0);
        send_item(KIND_RECORD, ALL48, '0);
        send_item(KIND_RECORD, TRACKED[47:0] - 48'd1, '0);
        send_item(KIND_RECORD, TRACKED[47:0], '0);
        send_item(KIND_RECORD, 48'd15, '0);
        send_item(KIND_RECORD, 48'd16, '0);
        send_item(KIND_REPORT, '0, 10'd1000);
        send_item(KIND_REPORT, '0, 10'd1023);
        send_item(KIND_REPORT, '0, 10'd512);
        send_item(KIND_REPORT, '0, 10'd999);
        send_item(KIND_UNUSED, ALL48, 10'd1023);
        send_item(KIND_REPORT, 48'h5555_5555_5555, 10'd1);
        send_item(KIND_CLEAR, ALL48, 10'd1023);
        send_item(KIND_REPORT, '0, 10'd300);
        send_item(KIND_RECORD, 48'haaaa_aaaa_aaaa, '0);
        send_item(KIND_RECORD, 48'h5555_5555_5555, '0);
        send_item(KIND_REPORT, ALL48, 10'd250);
        send_item(KIND_CLEAR, '0, '0);
    endtask

    // Batches of samples ended by a report, with the odd clear or unused item between them.
    task automatic test_random_phase(input int n, input int idle, input int stall);
        int k;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 80)
                send_item(KIND_RECORD, rand_latency(), 10'($urandom));
            else if (k < 95)
                send_item(KIND_REPORT, 48'({$urandom, $urandom}),
                          ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(1000)));
            else if (k < 98)
                send_item(KIND_CLEAR, 48'({$urandom, $urandom}), 10'($urandom));
            else
                send_item(KIND_UNUSED, 48'({$urandom, $urandom}), 10'($urandom));
        end
    endtask

    task automatic test_pause_until_drained();
        send_item(KIND_REPORT, '0, 10'd900);
        wait_drained();
        send_item(KIND_REPORT, '0, 10'd100);
    endtask

    initial
    begin
        failures          = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        kind              = KIND_RECORD;
        latency           = '0;
        percentile_tenths = '0;
        out_stall         = 1'b0;
        wipe_stats();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_edges();
        test_random_phase(290, 0, 0);
        test_pause_until_drained();
        test_random_phase(280, 61, 0);
        test_random_phase(280, 0, 61);
        test_random_phase(280, 30, 30);
        test_random_phase(0, 0, 0);

        wait_drained();
        repeat (2 * BINS + 300) @(posedge clk);
        if (failures == 0)
            $display("PASS latency_histogram_percentile");
        else
            $display("FAIL latency_histogram_percentile");
        $finish;
    end

    // Worst case: every item a full bucket walk plus receiver stalls.
    initial
    begin
        #100ms;
        $display("FAIL latency_histogram_percentile");
        $finish;
    end

endmodule

// ===== latency_histogram_percentile.f =====
hw/rtl/lhp_pkg.sv
hw/rtl/lhp_ram.sv
hw/rtl/lhp_div.sv
hw/rtl/lhp_ctrl.sv
hw/rtl/lhp_dp.sv
hw/rtl/latency_histogram_percentile.sv
bench/latency_histogram_percentile_test.sv
